/* hdl/sorted_priority_queue_core_defines.svh */
// assertion macros for the sorted priority queue core
// no dependencies; included by the top level only
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/spq_pkg.sv */
// shared types and codes for the sorted priority queue core
// no dependencies
`default_nettype none

package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int OUT_CNT_W    = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] val;
  } spq_ctl_t;

endpackage

`default_nettype wire

/* hdl/sorted_priority_queue_core.sv */
// sorted priority queue: a chain of compare-and-shift cells, ascending order
// one word per cycle unless stalled, through a registered result stage.
// insert: every cell compares its entry against the new value in parallel; the
// cells at or above the first entry not smaller than the value shift one place
// up and the value drops into the gap, so equal values go in front of the older
// ones. remove: every cell takes its upper neighbor's entry and the head comes
// out. clear only resets the count. each accepted word gives exactly one result
// word in the following cycle; the queue takes a word in every cycle in which the
// result register is empty or being drained, so throughput is one word per
// cycle, set by the registered cell update and the result register.
// depends on spq_pkg, spq_cell and sorted_priority_queue_core_defines.svh
`default_nettype none

`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         in_cmd,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STATUS_W-1:0]           out_status,
  output logic signed [DATA_W-1:0]      out_removed_value,
  output logic [OUT_CNT_W-1:0]          out_entry_count,
  output logic                          out_is_empty
);

  // count must hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // occupancy
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [STATUS_W-1:0]      status_r;
  logic [STATUS_W-1:0]      status_nxt;
  logic signed [DATA_W-1:0] removed_r;
  logic signed [DATA_W-1:0] removed_nxt;
  logic [CNT_W-1:0]         res_count_r;

  logic     accept;
  logic     full;
  logic     empty;
  spq_ctl_t ctl;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic                     cell_lt   [CAPACITY];

  // zero-extend before cutting to the five reported bits
  logic [CNT_W+OUT_CNT_W-1:0] res_count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign empty    = count_r == '0;

  // cell controls only fire for operations that actually change the store
  assign ctl.ins = accept && (in_cmd == CMD_INSERT) && !full;
  assign ctl.rem = accept && (in_cmd == CMD_REMOVE) && !empty;
  assign ctl.val = in_value;

  // the chain: each cell sees its lower neighbor's entry and compare flag,
  // and its upper neighbor's entry for the remove shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_lt;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      // on insert the head takes the new value whenever it does not stay put
      assign left_data = in_value;
      assign left_lt   = 1'b1;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // slot left behind by a remove is beyond the count, contents don't care
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_data  (left_data),
      .left_lt    (left_lt),
      .right_data (right_data),
      .data       (cell_data[i]),
      .lt         (cell_lt[i])
    );
  end

  // command decode: next count and the result word
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    unique case (in_cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt   = count_r - CNT_W'(1);
          removed_nxt = cell_data[0];
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unused code: no change, plain ok result
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload of the result register, loaded on every accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      removed_r   <= removed_nxt;
      res_count_r <= count_nxt;
    end
  end

  assign res_count_ext     = {{OUT_CNT_W{1'b0}}, res_count_r};
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = res_count_ext[OUT_CNT_W-1:0];
  assign out_is_empty      = res_count_r == '0;

  // checks on the count bookkeeping and the result word
  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY),
    "occupancy above capacity")
  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.ins,
    count_r == $past(count_r) + CNT_W'(1), "insert did not grow the count")
  `SPQ_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, ctl.rem,
    count_r == $past(count_r) - CNT_W'(1), "remove did not shrink the count")
  `SPQ_ASSERT_NOW(a_empty_status, clk, rst_n, out_valid_r && (status_r == ST_EMPTY),
    out_is_empty && (removed_r == '0), "empty status with entries or a value")
  `SPQ_ASSERT_NOW(a_full_status, clk, rst_n, out_valid_r && (status_r == ST_FULL),
    res_count_r == CNT_W'(CAPACITY), "full status below capacity")

endmodule

`default_nettype wire

/* hdl/spq_cell.sv */
// one slot of the sorted chain: holds an entry, shifts left or right
// depends on spq_pkg
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                     clk,
  input  wire spq_ctl_t                 ctl,
  input  wire logic [CNT_W-1:0]         count,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic                     left_lt,
  input  wire logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0]      data,
  output logic                          lt
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     occupied;

  assign occupied = CNT_W'(IDX) < count;
  // entry stays in place on insert when it is strictly smaller
  assign lt       = occupied && (data_r < ctl.val);
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (!lt) begin
        data_nxt = left_lt ? ctl.val : left_data;
      end
    end else if (ctl.rem) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire
